@@ hdl/rts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_pkg: shared types and constants of the thread scheduler
// Request codes, result codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package rts_pkg;

   localparam int ThreadSlots = 8;
   localparam int EventSlots  = 8;
   localparam int SlotW  = $clog2(ThreadSlots);
   localparam int EvtW   = $clog2(EventSlots);
   localparam int TCntW  = $clog2(ThreadSlots + 1);
   localparam int ECntW  = $clog2(EventSlots + 1);

   typedef enum logic [3:0] {
      REQ_TICK       = 4'd0,
      REQ_START      = 4'd1,
      REQ_ADD_THREAD = 4'd2,
      REQ_ADD_EVENT  = 4'd3,
      REQ_KILL_ID    = 4'd4,
      REQ_KILL_SELF  = 4'd5,
      REQ_KILL_OTHER = 4'd6,
      REQ_SLEEP      = 4'd7,
      REQ_YIELD      = 4'd8,
      REQ_SET_BLOCK  = 4'd9
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_EVENT  = 2'd1,
      KIND_CHOSEN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_LAST    = 2'd2,
      ST_NO_SUCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_EVENT,
      S_SCAN,
      S_PICK_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;       // capture request
      logic execute;     // apply request, emit any direct reply
      logic event_step;  // check one event slot
      logic scan_init;   // prepare event sweep and pick scan
      logic scan_step;   // examine one thread slot
      logic emit_pick;   // emit chosen thread result
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_events; // tick with armed events
      logic needs_pick;   // request ends with a pick
      logic event_done;   // last event slot examined
      logic scan_done;    // last thread slot examined
   } stat_type;

endpackage

@@ hdl/rts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_ctrl: scheduler controller
// Sequences decode, event sweep, pick scan and result emission.
// ----------------------------------------------------------------------------
module rts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rts_pkg::stat_type stat,
   output rts_pkg::ctrl_type ctrl
);

   rts_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rts_pkg::S_IDLE:   if (start) state_in = rts_pkg::S_DECODE;
         rts_pkg::S_DECODE: begin
            if (stat.needs_events) state_in = rts_pkg::S_EVENT;
            else if (stat.needs_pick) state_in = rts_pkg::S_SCAN;
            else state_in = rts_pkg::S_IDLE;
         end
         rts_pkg::S_EVENT:    if (stat.event_done) state_in = rts_pkg::S_SCAN;
         rts_pkg::S_SCAN:     if (stat.scan_done) state_in = rts_pkg::S_PICK_OUT;
         rts_pkg::S_PICK_OUT: state_in = rts_pkg::S_IDLE;
         default:             state_in = rts_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      busy = (state_ff != rts_pkg::S_IDLE);
      unique case (state_ff)
         rts_pkg::S_IDLE:   ctrl.latch = start;
         rts_pkg::S_DECODE: begin
            ctrl.execute   = 1'b1;
            ctrl.scan_init = 1'b1;
         end
         rts_pkg::S_EVENT:    ctrl.event_step = 1'b1;
         rts_pkg::S_SCAN:     ctrl.scan_step  = 1'b1;
         rts_pkg::S_PICK_OUT: ctrl.emit_pick  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rts_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   ast_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.execute, ctrl.event_step, ctrl.scan_step, ctrl.emit_pick}))
      else $error("multiple actions at once");
   ast_pick_after_scan: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_pick |-> $past(ctrl.scan_step))
      else $error("pick result without scan");
   ast_latch_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.latch |-> !busy)
      else $error("request latched while busy");

endmodule

@@ hdl/rts_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_datapath: scheduler tables and arithmetic
// Holds thread and event tables; one event or thread slot per scan cycle.
// ----------------------------------------------------------------------------
module rts_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  rts_pkg::ctrl_type          ctrl,
   output rts_pkg::stat_type          stat,
   input  logic [3:0]                 req_type,
   input  logic [7:0]                 req_priority_req,
   input  logic [31:0]                req_thread_id,
   input  logic [2:0]                 req_slot,
   input  logic [31:0]                req_duration,
   input  logic                       req_block_value,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_kind,
   output logic [1:0]                 rsp_status,
   output logic [2:0]                 rsp_index,
   output logic [31:0]                rsp_result_id,
   output logic                       rsp_last
);

   localparam int SW = rts_pkg::SlotW;
   localparam int EW = rts_pkg::EvtW;
   localparam int NT = rts_pkg::ThreadSlots;
   localparam int NE = rts_pkg::EventSlots;

   // request capture
   logic [3:0]  rq_type_ff;
   logic [7:0]  rq_prio_ff;
   logic [31:0] rq_tid_ff, rq_dur_ff;
   logic [2:0]  rq_slot_ff;
   logic        rq_bval_ff;

   // thread table
   logic [NT-1:0] alive_ff, asleep_ff, blocked_ff;
   logic [7:0]    prio_ff [NT];
   logic [31:0]   wake_ff [NT];
   logic [15:0]   tag_ff  [NT];
   logic [15:0]   idcnt_ff;
   logic [SW-1:0] cur_ff;
   logic [rts_pkg::TCntW-1:0] tcount_ff;
   logic [31:0]   time_ff;

   // event table (memory, undefined until written)
   logic [31:0] ev_period_mem [NE];
   logic [31:0] ev_due_mem    [NE];
   logic [rts_pkg::ECntW-1:0] ecount_ff;

   // scan state
   logic [EW-1:0] ev_idx_ff;
   logic [SW-1:0] sc_off_ff;
   logic [8:0]    best_ff;
   logic [SW-1:0] chosen_ff;

   // output registers
   logic        o_strobe_ff, o_last_ff;
   logic [1:0]  o_kind_ff, o_status_ff;
   logic [2:0]  o_index_ff;
   logic [31:0] o_id_ff;

   function automatic logic [31:0] id_of(input logic [15:0] tag, input logic [SW-1:0] s);
      return {tag, 16'(s)};
   endfunction

   // decode helpers
   logic [SW-1:0] free_slot;
   logic          free_found;
   logic [SW-1:0] kill_slot;
   logic          kill_found;
   logic [SW-1:0] start_slot;
   logic [8:0]    start_best;
   logic [SW-1:0] blk_slot;
   logic          blk_ok;
   logic [31:0]   time_next;

   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      kill_slot  = '0;
      kill_found = 1'b0;
      start_slot = '0;
      start_best = 9'd256;
      for (int s = NT - 1; s >= 0; s--) begin
         if (!alive_ff[s]) begin
            free_slot  = SW'(s);
            free_found = 1'b1;
         end
         if (alive_ff[s] && id_of(tag_ff[s], SW'(s)) == rq_tid_ff) begin
            kill_slot  = SW'(s);
            kill_found = 1'b1;
         end
      end
      for (int s = 0; s < NT; s++) begin
         if (alive_ff[s] && {1'b0, prio_ff[s]} < start_best) begin
            start_best = {1'b0, prio_ff[s]};
            start_slot = SW'(s);
         end
      end
      blk_ok   = ({29'd0, rq_slot_ff} < 32'(NT));
      blk_slot = SW'(rq_slot_ff);
      time_next = time_ff + 32'd1;
   end

   // scan candidate
   logic [SW-1:0] sc_slot;
   logic          sc_last;
   assign sc_slot = cur_ff + sc_off_ff + SW'(1);
   assign sc_last = (sc_off_ff == SW'(NT - 1));

   logic ev_last;
   assign ev_last = (32'(ev_idx_ff) + 32'd1 >= 32'(ecount_ff));

   // pick-needed decision at decode
   logic pick_need;
   always_comb begin
      pick_need = 1'b0;
      case (rq_type_ff)
         rts_pkg::REQ_TICK, rts_pkg::REQ_SLEEP, rts_pkg::REQ_YIELD: pick_need = 1'b1;
         rts_pkg::REQ_KILL_ID:
            pick_need = (tcount_ff != 1) && kill_found && (kill_slot == cur_ff);
         rts_pkg::REQ_KILL_SELF:
            pick_need = (tcount_ff != 1) && alive_ff[cur_ff];
         default: pick_need = 1'b0;
      endcase
   end

   always_comb begin
      stat.needs_events = (rq_type_ff == rts_pkg::REQ_TICK) && (ecount_ff != '0);
      stat.needs_pick   = pick_need;
      stat.event_done   = ev_last;
      stat.scan_done    = sc_last;
   end

   always_ff @(posedge clock) begin
      o_strobe_ff <= 1'b0;
      if (ctrl.latch) begin
         rq_type_ff <= req_type;
         rq_prio_ff <= req_priority_req;
         rq_tid_ff  <= req_thread_id;
         rq_slot_ff <= req_slot;
         rq_dur_ff  <= req_duration;
         rq_bval_ff <= req_block_value;
      end

      if (ctrl.scan_init) begin
         sc_off_ff <= '0;
         ev_idx_ff <= '0;
         best_ff   <= 9'd256;
         chosen_ff <= cur_ff;
      end

      // request handling at decode
      if (ctrl.execute) begin
         o_kind_ff   <= rts_pkg::KIND_STATUS;
         o_status_ff <= rts_pkg::ST_OK;
         o_index_ff  <= '0;
         o_id_ff     <= '0;
         o_last_ff   <= 1'b1;
         o_strobe_ff <= 1'b0;
         case (rq_type_ff)
            rts_pkg::REQ_TICK: begin
               time_ff <= time_next;
               for (int s = 0; s < NT; s++)
                  if (asleep_ff[s] && wake_ff[s] <= time_next) asleep_ff[s] <= 1'b0;
            end
            rts_pkg::REQ_START: begin
               cur_ff      <= start_slot;
               o_kind_ff   <= rts_pkg::KIND_CHOSEN;
               o_index_ff  <= 3'(start_slot);
               o_id_ff     <= id_of(tag_ff[start_slot], start_slot);
               o_strobe_ff <= 1'b1;
            end
            rts_pkg::REQ_ADD_THREAD: begin
               o_strobe_ff <= 1'b1;
               if (!free_found || tcount_ff >= rts_pkg::TCntW'(NT))
                  o_status_ff <= rts_pkg::ST_FULL;
               else begin
                  alive_ff[free_slot]   <= 1'b1;
                  prio_ff[free_slot]    <= rq_prio_ff;
                  tag_ff[free_slot]     <= idcnt_ff;
                  blocked_ff[free_slot] <= 1'b0;
                  asleep_ff[free_slot]  <= 1'b0;
                  idcnt_ff  <= idcnt_ff + 16'd1;
                  tcount_ff <= tcount_ff + 1'b1;
                  o_index_ff <= 3'(free_slot);
                  o_id_ff    <= id_of(idcnt_ff, free_slot);
               end
            end
            rts_pkg::REQ_ADD_EVENT: begin
               o_strobe_ff <= 1'b1;
               if (ecount_ff >= rts_pkg::ECntW'(NE)) o_status_ff <= rts_pkg::ST_FULL;
               else begin
                  ev_period_mem[EW'(ecount_ff)] <= rq_dur_ff;
                  ev_due_mem[EW'(ecount_ff)]    <= time_ff + rq_dur_ff;
                  ecount_ff  <= ecount_ff + 1'b1;
                  o_index_ff <= 3'(ecount_ff);
               end
            end
            rts_pkg::REQ_KILL_ID: begin
               o_strobe_ff <= 1'b1;
               if (tcount_ff == 1) o_status_ff <= rts_pkg::ST_LAST;
               else if (!kill_found) o_status_ff <= rts_pkg::ST_NO_SUCH;
               else begin
                  alive_ff[kill_slot]   <= 1'b0;
                  blocked_ff[kill_slot] <= 1'b0;
                  asleep_ff[kill_slot]  <= 1'b0;
                  wake_ff[kill_slot]    <= '0;
                  tcount_ff  <= tcount_ff - 1'b1;
                  o_index_ff <= 3'(kill_slot);
                  o_id_ff    <= rq_tid_ff;
                  o_last_ff  <= (kill_slot != cur_ff);
               end
            end
            rts_pkg::REQ_KILL_SELF: begin
               o_strobe_ff <= 1'b1;
               if (tcount_ff == 1) o_status_ff <= rts_pkg::ST_LAST;
               else if (!alive_ff[cur_ff]) o_status_ff <= rts_pkg::ST_NO_SUCH;
               else begin
                  alive_ff[cur_ff] <= 1'b0;
                  tcount_ff  <= tcount_ff - 1'b1;
                  o_index_ff <= 3'(cur_ff);
                  o_id_ff    <= id_of(tag_ff[cur_ff], cur_ff);
                  o_last_ff  <= 1'b0;
               end
            end
            rts_pkg::REQ_KILL_OTHER: begin
               o_strobe_ff <= 1'b1;
               if (tcount_ff == 1) o_status_ff <= rts_pkg::ST_LAST;
               else if (!alive_ff[cur_ff]) o_status_ff <= rts_pkg::ST_NO_SUCH;
               else begin
                  for (int s = 0; s < NT; s++)
                     if (SW'(s) != cur_ff) alive_ff[s] <= 1'b0;
                  tcount_ff  <= rts_pkg::TCntW'(1);
                  o_index_ff <= 3'(cur_ff);
                  o_id_ff    <= id_of(tag_ff[cur_ff], cur_ff);
               end
            end
            rts_pkg::REQ_SLEEP: begin
               if (alive_ff[cur_ff]) begin
                  wake_ff[cur_ff]   <= time_ff + rq_dur_ff;
                  asleep_ff[cur_ff] <= 1'b1;
               end
            end
            rts_pkg::REQ_YIELD: ;
            rts_pkg::REQ_SET_BLOCK: begin
               o_strobe_ff <= 1'b1;
               if (!blk_ok) o_status_ff <= rts_pkg::ST_NO_SUCH;
               else begin
                  blocked_ff[blk_slot] <= rq_bval_ff;
                  o_index_ff <= 3'(blk_slot);
                  o_id_ff    <= id_of(tag_ff[blk_slot], blk_slot);
               end
            end
            default: o_strobe_ff <= 1'b1;
         endcase
      end

      // fire due events, one slot a cycle
      if (ctrl.event_step) begin
         ev_idx_ff <= ev_idx_ff + 1'b1;
         if (ev_due_mem[ev_idx_ff] == time_ff) begin
            ev_due_mem[ev_idx_ff] <= time_ff + ev_period_mem[ev_idx_ff];
            o_strobe_ff <= 1'b1;
            o_kind_ff   <= rts_pkg::KIND_EVENT;
            o_status_ff <= rts_pkg::ST_OK;
            o_index_ff  <= 3'(ev_idx_ff);
            o_id_ff     <= '0;
            o_last_ff   <= 1'b0;
         end
      end

      // round-robin priority scan, one slot a cycle
      if (ctrl.scan_step) begin
         sc_off_ff <= sc_off_ff + 1'b1;
         if (alive_ff[sc_slot] && !blocked_ff[sc_slot] && !asleep_ff[sc_slot]
             && {1'b0, prio_ff[sc_slot]} < best_ff) begin
            best_ff   <= {1'b0, prio_ff[sc_slot]};
            chosen_ff <= sc_slot;
         end
      end

      if (ctrl.emit_pick) begin
         cur_ff      <= chosen_ff;
         o_strobe_ff <= 1'b1;
         o_kind_ff   <= rts_pkg::KIND_CHOSEN;
         o_status_ff <= rts_pkg::ST_OK;
         o_index_ff  <= 3'(chosen_ff);
         o_id_ff     <= id_of(tag_ff[chosen_ff], chosen_ff);
         o_last_ff   <= 1'b1;
      end

      if (reset) begin
         o_strobe_ff <= 1'b0;
         alive_ff    <= '0;
         asleep_ff   <= '0;
         blocked_ff  <= '0;
         for (int s = 0; s < NT; s++) begin
            prio_ff[s] <= '0;
            wake_ff[s] <= '0;
            tag_ff[s]  <= '0;
         end
         idcnt_ff  <= '0;
         cur_ff    <= '0;
         tcount_ff <= '0;
         time_ff   <= '0;
         ecount_ff <= '0;
      end
   end

   assign rsp_strobe    = o_strobe_ff;
   assign rsp_kind      = o_kind_ff;
   assign rsp_status    = o_status_ff;
   assign rsp_index     = o_index_ff;
   assign rsp_result_id = o_id_ff;
   assign rsp_last      = o_last_ff;

   ast_count_range: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= rts_pkg::TCntW'(NT))
      else $error("thread count out of range");
   ast_count_alive: assert property (@(posedge clock) disable iff (reset)
      ecount_ff <= rts_pkg::ECntW'(NE))
      else $error("event count out of range");
   ast_pick_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_pick |=> rsp_strobe && rsp_last)
      else $error("pick result missing last");

endmodule

@@ hdl/rtos_thread_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtos_thread_scheduler_top: hardware thread scheduler
// Priority round-robin scheduler over eight thread slots and eight events.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_* and pulse start while busy is low; the item is taken at
//   that edge and busy rises the next cycle; it falls in the cycle the
//   final result is shown. Each result appears for one cycle with
//   rsp_strobe high; rsp_last marks the final one. The receiver cannot
//   stall, so results must be captured on the cycle they show.
// Request flow:
//   Simple requests: decode applies the request and registers its reply.
//   Requests that pick a thread: decode, a scan of all eight thread slots
//   in turn, then an output state that registers the chosen result.
//   Tick: an event sweep over every armed event slot (event table read port)
//   runs ahead of the thread scan.
// Reset: synchronous; clears all thread state, time and counters. Event
//   table contents stay undefined until written.
// ----------------------------------------------------------------------------
module rtos_thread_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_type,
   input  logic [7:0]  req_priority_req,
   input  logic [31:0] req_thread_id,
   input  logic [2:0]  req_slot,
   input  logic [31:0] req_duration,
   input  logic        req_block_value,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_index,
   output logic [31:0] rsp_result_id,
   output logic        rsp_last
);

   rts_pkg::ctrl_type ctrl;
   rts_pkg::stat_type stat;

   rts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   rts_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_type         (req_type),
      .req_priority_req (req_priority_req),
      .req_thread_id    (req_thread_id),
      .req_slot         (req_slot),
      .req_duration     (req_duration),
      .req_block_value  (req_block_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_index        (rsp_index),
      .rsp_result_id    (rsp_result_id),
      .rsp_last         (rsp_last)
   );

endmodule

@@ tb/rtos_thread_scheduler_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtos_thread_scheduler_top_tb: self-checking bench of the thread scheduler
// Sends directed and random requests through the start/busy port, predicts
// every result with a behavioral scheduler model and checks each strobed
// result in order against the predicted queue.
// ----------------------------------------------------------------------------
module rtos_thread_scheduler_top_tb;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [2:0]  index;
      logic [31:0] result_id;
      logic        last;
   } sched_result_type;

   localparam int PrioNone = 256;
   localparam int NT = rts_pkg::ThreadSlots;
   localparam int NE = rts_pkg::EventSlots;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_type = '0;
   logic [7:0]  req_priority_req = '0;
   logic [31:0] req_thread_id = '0;
   logic [2:0]  req_slot = '0;
   logic [31:0] req_duration = '0;
   logic        req_block_value = 1'b0;
   logic        rsp_strobe;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_index;
   logic [31:0] rsp_result_id;
   logic        rsp_last;

   // scheduler state of the predictor
   logic        alive [NT];
   logic [7:0]  prio [NT];
   logic        asleep [NT];
   logic        blocked [NT];
   logic [31:0] wake_at [NT];
   logic [15:0] tag [NT];
   logic [15:0] next_tag;
   logic [2:0]  cur;
   int          live_count;
   logic [31:0] now;
   logic [31:0] period [NE];
   logic [31:0] due [NE];
   int          armed;

   sched_result_type pending_results[$];
   int  mismatches = 0;
   bit  gaps_on = 1'b1;

   rtos_thread_scheduler_top i_dut (.*);

   always #2 clock = ~clock;

   task automatic report(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sched_result_type got, want;
         got = '{rsp_kind, rsp_status, rsp_index, rsp_result_id, rsp_last};
         if (pending_results.size() == 0) report($sformatf("unexpected %p", got));
         else begin
            want = pending_results.pop_front();
            if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
            if (got.status != want.status)
               report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.index != want.index)
               report($sformatf("index %0d want %0d", got.index, want.index));
            if (got.result_id != want.result_id)
               report($sformatf("id %h want %h", got.result_id, want.result_id));
            if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
         end
      end
   end

   function automatic logic [31:0] id_of(input int s);
      return {tag[s], 13'd0, 3'(s)};
   endfunction

   function automatic void push(input rts_pkg::kind_type k, input rts_pkg::status_type st,
                                input int idx, input logic [31:0] id, input logic lst);
      pending_results.push_back('{k, st, 3'(idx), id, lst});
   endfunction

   function automatic void pick_next();
      int best, chosen, s;
      best = PrioNone;
      chosen = cur;
      for (int k = 1; k <= NT; k++) begin
         s = (cur + k) % NT;
         if (alive[s] && !blocked[s] && !asleep[s] && prio[s] < best) begin
            best = prio[s];
            chosen = s;
         end
      end
      cur = 3'(chosen);
      push(rts_pkg::KIND_CHOSEN, rts_pkg::ST_OK, cur, id_of(cur), 1'b1);
   endfunction

   function automatic void clear_sched();
      for (int s = 0; s < NT; s++) begin
         alive[s] = 0; prio[s] = 0; asleep[s] = 0; blocked[s] = 0;
         wake_at[s] = 0; tag[s] = 0;
      end
      next_tag = 0; cur = 0; live_count = 0; now = 0; armed = 0;
   endfunction

   // predict the results of one accepted request
   function automatic void predict_request(input logic [3:0] rq, input logic [7:0] pr,
                                           input logic [31:0] tid, input logic [2:0] bs,
                                           input logic [31:0] dur, input logic bv);
      int s, best;
      case (rq)
         rts_pkg::REQ_TICK: begin
            now = now + 1;
            for (int i = 0; i < armed; i++)
               if (due[i] == now) begin
                  due[i] = now + period[i];
                  push(rts_pkg::KIND_EVENT, rts_pkg::ST_OK, i, 0, 1'b0);
               end
            for (s = 0; s < NT; s++)
               if (asleep[s] && wake_at[s] <= now) asleep[s] = 0;
            pick_next();
         end
         rts_pkg::REQ_START: begin
            best = alive[0] ? prio[0] : PrioNone;
            cur = 0;
            for (s = 1; s < NT; s++)
               if (alive[s] && prio[s] < best) begin
                  best = prio[s];
                  cur = 3'(s);
               end
            push(rts_pkg::KIND_CHOSEN, rts_pkg::ST_OK, cur, id_of(cur), 1'b1);
         end
         rts_pkg::REQ_ADD_THREAD: begin
            for (s = 0; s < NT && alive[s]; s++);
            if (live_count >= NT || s >= NT)
               push(rts_pkg::KIND_STATUS, rts_pkg::ST_FULL, 0, 0, 1);
            else begin
               alive[s] = 1; prio[s] = pr; tag[s] = next_tag; next_tag++;
               blocked[s] = 0; asleep[s] = 0; live_count++;
               push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, s, id_of(s), 1'b1);
            end
         end
         rts_pkg::REQ_ADD_EVENT: begin
            if (armed >= NE) push(rts_pkg::KIND_STATUS, rts_pkg::ST_FULL, 0, 0, 1);
            else begin
               period[armed] = dur; due[armed] = now + dur;
               push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, armed, 0, 1'b1);
               armed++;
            end
         end
         rts_pkg::REQ_KILL_ID: begin
            if (live_count == 1) push(rts_pkg::KIND_STATUS, rts_pkg::ST_LAST, 0, 0, 1);
            else begin
               for (s = 0; s < NT; s++) if (alive[s] && id_of(s) == tid) break;
               if (s >= NT) push(rts_pkg::KIND_STATUS, rts_pkg::ST_NO_SUCH, 0, 0, 1);
               else begin
                  alive[s] = 0; blocked[s] = 0; asleep[s] = 0; wake_at[s] = 0;
                  live_count--;
                  push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, s, tid, s != cur);
                  if (s == cur) pick_next();
               end
            end
         end
         rts_pkg::REQ_KILL_SELF, rts_pkg::REQ_KILL_OTHER: begin
            if (live_count == 1) push(rts_pkg::KIND_STATUS, rts_pkg::ST_LAST, 0, 0, 1);
            else if (!alive[cur]) push(rts_pkg::KIND_STATUS, rts_pkg::ST_NO_SUCH, 0, 0, 1);
            else if (rq == rts_pkg::REQ_KILL_SELF) begin
               alive[cur] = 0; live_count--;
               push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, cur, id_of(cur), 1'b0);
               pick_next();
            end else begin
               for (s = 0; s < NT; s++) if (s != cur) alive[s] = 0;
               live_count = 1;
               push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, cur, id_of(cur), 1'b1);
            end
         end
         rts_pkg::REQ_SLEEP: begin
            if (alive[cur]) begin
               wake_at[cur] = now + dur; asleep[cur] = 1;
            end
            pick_next();
         end
         rts_pkg::REQ_YIELD: pick_next();
         rts_pkg::REQ_SET_BLOCK: begin
            blocked[bs] = bv;
            push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, bs, id_of(bs), 1'b1);
         end
         default: push(rts_pkg::KIND_STATUS, rts_pkg::ST_OK, 0, 0, 1);
      endcase
   endfunction

   task automatic idle_burst();
      if (gaps_on && $urandom_range(3) == 0) repeat ($urandom_range(1, 16)) @(posedge clock);
   endtask

   // send one item and wait for it to be taken
   task automatic send_request(input logic [3:0] rq, input logic [7:0] pr = 0,
                               input logic [31:0] tid = 0, input logic [2:0] bs = 0,
                               input logic [31:0] dur = 0, input logic bv = 0);
      idle_burst();
      req_type <= rq; req_priority_req <= pr; req_thread_id <= tid;
      req_slot <= bs; req_duration <= dur; req_block_value <= bv;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(rq, pr, tid, bs, dur, bv);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random();
      logic [3:0] rq;
      logic [31:0] tid;
      int s;
      s = $urandom_range(NT - 1);
      rq = 4'($urandom_range(9));
      if ($urandom_range(19) == 0) rq = 4'($urandom_range(10, 15));
      tid = ($urandom_range(3) != 0) ? id_of(s) : $urandom;
      send_request(rq, 8'($urandom_range(3) == 0 ? $urandom : $urandom_range(4)),
                   tid, 3'(s),
                   $urandom_range(4) == 0 ? $urandom : $urandom_range(6),
                   $urandom_range(2) == 0);
   endtask

   task automatic test_empty_table();
      send_request(rts_pkg::REQ_TICK);
      send_request(rts_pkg::REQ_START);
      send_request(rts_pkg::REQ_YIELD);
      send_request(rts_pkg::REQ_SLEEP, 0, 0, 0, 3);
      send_request(rts_pkg::REQ_KILL_SELF);
      send_request(rts_pkg::REQ_KILL_OTHER);
      send_request(4'd15);
   endtask

   task automatic test_table_limits();
      send_request(rts_pkg::REQ_ADD_THREAD, 8'hFF);
      send_request(rts_pkg::REQ_KILL_ID, 0, 32'h0);
      for (int i = 0; i < NT; i++) send_request(rts_pkg::REQ_ADD_THREAD, 8'(i * 37));
      send_request(rts_pkg::REQ_ADD_THREAD, 8'h00);
      for (int i = 0; i <= NE; i++)
         send_request(rts_pkg::REQ_ADD_EVENT, 0, 0, 0, 32'(i == 0 ? 1 : i));
      send_request(rts_pkg::REQ_START);
   endtask

   task automatic test_scheduling_cases();
      send_request(rts_pkg::REQ_SET_BLOCK, 0, 0, 3'd7, 0, 1'b1);
      send_request(rts_pkg::REQ_SLEEP, 0, 0, 0, 32'hFFFF_FFFF);
      send_request(rts_pkg::REQ_TICK);
      send_request(rts_pkg::REQ_KILL_ID, 0, id_of(3));
      send_request(rts_pkg::REQ_KILL_ID, 0, 32'hFFFF_FFFF);
      send_request(rts_pkg::REQ_KILL_ID, 0, id_of(cur));
      send_request(rts_pkg::REQ_KILL_SELF);
      send_request(rts_pkg::REQ_KILL_OTHER);
      send_request(rts_pkg::REQ_KILL_SELF);
      send_request(rts_pkg::REQ_SET_BLOCK, 0, 0, 3'd0, 0, 1'b0);
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < 85; n++) begin
         if (n == 65) gaps_on = 1'b0;
         if (live_count < 3 && $urandom_range(1))
            send_request(rts_pkg::REQ_ADD_THREAD, 8'($urandom_range(5)));
         else send_random();
      end
   endtask

   initial begin
      clear_sched();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_table_limits();
      test_scheduling_cases();
      test_random_traffic();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("rtos_thread_scheduler_top_tb passed");
      else
         $display("rtos_thread_scheduler_top_tb failed");
      $finish;
   end

   // stop a hung run
   initial begin
      #400000;
      $display("rtos_thread_scheduler_top_tb failed");
      $finish;
   end

endmodule
